// File: rtl/lpse_pkg.sv
// ============================================================================
// lpse_pkg: shared types and constants of the LED PWM slot encoder
// Item and result structs, the slot command queued between front and back,
// configuration register codes and reset values.
// ============================================================================
`timescale 1ns / 1ps

package lpse_pkg;

    // Bits sent per pixel slot
    localparam int BITS_PER_PIXEL = 24;
    localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL);

    // Slot command queue
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY = 2'd2;

    localparam logic [8:0] LED_COUNT_RST = 9'd256;
    localparam logic [7:0] ONE_DUTY_RST  = 8'd49;
    localparam logic [7:0] ZERO_DUTY_RST = 8'd20;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SLOT  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] duty_value;
        logic       is_gap;
        logic       last_of_slot;
    } out_item_t;

    typedef struct packed {
        logic [8:0] led_count;
        logic [7:0] one_duty;
        logic [7:0] zero_duty;
    } cfg_t;

    // One slot of work: gap flag and the color bits in send order
    typedef struct packed {
        logic                      gap;
        logic [BITS_PER_PIXEL-1:0] bits;
    } slot_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

// File: rtl/lpse_front.sv
// ============================================================================
// lpse_front: item intake, pixel store and slot classification
// Writes pixels into the store, decides pixel or gap for each slot item,
// reads the pixel and hands a slot command to the queue.
// ============================================================================
`timescale 1ns / 1ps

module lpse_front #(
    parameter int PIXEL_DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  lpse_pkg::in_item_t           item,
    input  lpse_pkg::cfg_t               cfg,
    input  lpse_pkg::q_status_t          q_status,
    output logic                         push,
    output lpse_pkg::slot_cmd_t          push_cmd
);
    import lpse_pkg::*;

    localparam int AW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
    localparam int XW = AW + 9;

    // Pixel store, colors kept in send order (blue, green, red)
    logic [BITS_PER_PIXEL-1:0] mem [PIXEL_DEPTH];
    logic [BITS_PER_PIXEL-1:0] rdata_reg;

    logic          clear_reg, clear_next;
    logic [AW-1:0] clr_idx_reg, clr_idx_next;
    logic [8:0]    slot_pos_reg, slot_pos_next;
    logic          second_gap_reg, second_gap_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_gap_reg, s1_gap_next;

    logic                      accept;
    logic                      is_slot;
    logic                      room;
    logic [XW-1:0]             idx_x;
    logic [XW-1:0]             pos_x;
    logic [XW-1:0]             count_x;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [BITS_PER_PIXEL-1:0] mem_wdata;
    logic                      mem_re;

    // Room in the queue counts the read still in flight
    assign is_slot    = (item.req_type == REQ_SLOT);
    assign room       = ((QCNT_W+1)'(q_status.count) + (QCNT_W+1)'(s1_valid_reg))
                        < (QCNT_W+1)'(QDEPTH);
    assign item_ready = !clear_reg && (!is_slot || room);
    assign accept     = item_valid && item_ready;

    // Widen positions so any store depth compares cleanly
    assign idx_x   = XW'(item.pixel_index);
    assign pos_x   = XW'(slot_pos_reg);
    assign count_x = (XW'(cfg.led_count) > XW'(PIXEL_DEPTH)) ? XW'(PIXEL_DEPTH)
                                                              : XW'(cfg.led_count);

    // Store write port: clearing sweep or pixel write
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_idx_reg;
        mem_wdata = '0;
        if (clear_reg)
        begin
            mem_we = 1'b1;
        end
        else if (accept && !is_slot && (idx_x < XW'(PIXEL_DEPTH)))
        begin
            mem_we    = 1'b1;
            mem_waddr = idx_x[AW-1:0];
            mem_wdata = {item.blue, item.green, item.red};
        end
    end

    // Classify slot items and advance the frame position
    always_comb
    begin
        clear_next      = clear_reg;
        clr_idx_next    = clr_idx_reg;
        slot_pos_next   = slot_pos_reg;
        second_gap_next = second_gap_reg;
        s1_valid_next   = 1'b0;
        s1_gap_next     = s1_gap_reg;
        mem_re          = 1'b0;

        if (clear_reg)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == AW'(PIXEL_DEPTH - 1))
            begin
                clear_next = 1'b0;
            end
        end

        if (accept && is_slot)
        begin
            s1_valid_next = 1'b1;
            if (second_gap_reg)
            begin
                second_gap_next = 1'b0;
                s1_gap_next     = 1'b1;
            end
            else if (pos_x >= count_x)
            begin
                second_gap_next = 1'b1;
                slot_pos_next   = '0;
                s1_gap_next     = 1'b1;
            end
            else
            begin
                mem_re        = 1'b1;
                s1_gap_next   = 1'b0;
                slot_pos_next = slot_pos_reg + 9'd1;
            end
        end
    end

    // Store access, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[pos_x[AW-1:0]];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clr_idx_reg    <= '0;
            slot_pos_reg   <= '0;
            second_gap_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            clear_reg      <= clear_next;
            clr_idx_reg    <= clr_idx_next;
            slot_pos_reg   <= slot_pos_next;
            second_gap_reg <= second_gap_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_gap_reg <= s1_gap_next;
    end

    // Hand the slot command to the queue
    assign push          = s1_valid_reg;
    assign push_cmd.gap  = s1_gap_reg;
    assign push_cmd.bits = rdata_reg;

    // A queued slot always finds a free entry
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (q_status.count < QCNT_W'(QDEPTH)))
        else $error("slot command pushed into a full queue");

    // No item is taken while the store is being cleared
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !item_ready)
        else $error("item accepted during store clearing");

endmodule

// File: rtl/lpse_queue.sv
// ============================================================================
// lpse_queue: slot command queue
// Short FIFO between the front and the back so each side can stall alone.
// ============================================================================
`timescale 1ns / 1ps

module lpse_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  lpse_pkg::slot_cmd_t     push_cmd,
    input  logic                    pop,
    output lpse_pkg::slot_cmd_t     head,
    output lpse_pkg::q_status_t     q_status
);
    import lpse_pkg::*;

    slot_cmd_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.count = count_reg;

    // Fill level stays within the queue depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("slot queue overflow");

endmodule

// File: rtl/lpse_back.sv
// ============================================================================
// lpse_back: slot serializer
// Turns one slot command into 24 duty values, one per cycle while the
// receiver is ready, into a registered output stage.
// ============================================================================
`timescale 1ns / 1ps

module lpse_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lpse_pkg::cfg_t          cfg,
    input  lpse_pkg::q_status_t     q_status,
    input  lpse_pkg::slot_cmd_t     head,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_ready,
    output lpse_pkg::out_item_t     result
);
    import lpse_pkg::*;

    logic                      busy_reg, busy_next;
    logic [BIT_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                      gap_reg, gap_next;
    logic [BITS_PER_PIXEL-1:0] shift_reg, shift_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg, out_next;

    logic advance;
    logic last;

    assign advance = busy_reg && (!out_valid_reg || result_ready);
    assign last    = (cnt_reg == BIT_CNT_W'(BITS_PER_PIXEL - 1));
    assign pop     = q_status.valid && (!busy_reg || (advance && last));

    // One bit period per stall-free cycle, next slot loaded on the last one
    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        gap_next       = gap_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (advance)
        begin
            out_valid_next        = 1'b1;
            out_next.duty_value   = gap_reg ? 8'd0 :
                                    (shift_reg[BITS_PER_PIXEL-1] ? cfg.one_duty
                                                                 : cfg.zero_duty);
            out_next.is_gap       = gap_reg;
            out_next.last_of_slot = last;
            shift_next            = {shift_reg[BITS_PER_PIXEL-2:0], 1'b0};
            cnt_next              = cnt_reg + BIT_CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            gap_next   = head.gap;
            shift_next = head.bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg   <= gap_next;
        shift_reg <= shift_next;
        out_reg   <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Gap periods always carry a zero duty
    a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.is_gap) |-> (out_reg.duty_value == 8'd0))
        else $error("gap period with nonzero duty");

    // Bit counter stays within one slot
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg < BIT_CNT_W'(BITS_PER_PIXEL)))
        else $error("bit counter beyond slot length");

    // A finished slot is followed by an idle back or a fresh slot
    a_slot_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last && !pop) |=> !busy_reg)
        else $error("serializer still busy after last period");

endmodule

// File: rtl/led_pwm_slot_encoder_unit.sv
// ============================================================================
// led_pwm_slot_encoder_unit: one-wire LED PWM slot encoder
// A slot item passes the pixel read register and the queue to the serializer,
// which sets the output register. Throughput: one result per cycle while the
// receiver is ready, 24 per slot item; pixel writes are taken one per cycle.
// Reset: the pixel store is cleared by a sweep of PIXEL_DEPTH cycles, during
// which no item is accepted; configuration writes are taken throughout.
// ============================================================================
`timescale 1ns / 1ps

module led_pwm_slot_encoder_unit #(
    parameter int PIXEL_DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  lpse_pkg::in_item_t                    item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output lpse_pkg::out_item_t                   result,
    input  logic                                  cfg_we,
    input  logic [lpse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lpse_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import lpse_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    q_status_t q_status;
    slot_cmd_t push_cmd;
    slot_cmd_t head;
    logic      push;
    logic      pop;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LED_COUNT: cfg_next.led_count = cfg_data;
                REG_ONE_DUTY:  cfg_next.one_duty  = cfg_data[7:0];
                REG_ZERO_DUTY: cfg_next.zero_duty = cfg_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_count <= LED_COUNT_RST;
            cfg_reg.one_duty  <= ONE_DUTY_RST;
            cfg_reg.zero_duty <= ZERO_DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lpse_front #(
        .PIXEL_DEPTH (PIXEL_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    lpse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    lpse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: tb/led_pwm_slot_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// led_pwm_slot_encoder_unit_tb: self-checking bench of the LED PWM slot encoder
// A directed table hits reset contents, register extremes, dropped register
// bits, zero and saturated pixel counts and a count lowered mid-frame. Random
// phases with fresh register settings follow. Each duty value is compared to
// the plan or an in-bench encoder under bursty input and a stalling receiver.
// ============================================================================

module led_pwm_slot_encoder_unit_tb;

    import lpse_pkg::*;

    localparam int PIXEL_DEPTH     = 256;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_AFTER      = 120;
    localparam int LONG_HOLD       = 200;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 41;
    localparam int NUM_ROWS        = 31;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SLOT, ROW_REGS} row_kind_e;
    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_e;

    typedef struct {
        row_kind_e   kind;
        logic [7:0]  index;
        logic [23:0] rgb;
        logic [8:0]  lc;
        logic [8:0]  one;
        logic [8:0]  zero;
        bit          typed;
        logic [7:0]  duty;
        logic        gap;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    in_item_t              item;
    logic                  result_valid;
    logic                  result_ready;
    out_item_t             result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow state of the encoder
    logic [23:0] shadow_pixels [PIXEL_DEPTH];
    cfg_t        shadow_cfg;
    logic [8:0]  slot_pos;
    logic        gap_owed;
    out_item_t   slot_duties [BITS_PER_PIXEL];
    out_item_t   pending_duties [$];

    int errors;
    int results_taken;
    int items_sent;
    int slots_sent;
    int settings_done;
    int burst_left;
    int quiet_cycles;

    // Directed items: expected duty typed in where it reads off at a glance
    plan_row_t plan [NUM_ROWS] = '{
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, ZERO_DUTY_RST, 1'b0},
        '{ROW_WRITE, 8'd1,   24'hFFFFFF, 9'd0,   9'd0,     9'd0,     1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, ONE_DUTY_RST,  1'b0},
        '{ROW_WRITE, 8'd2,   24'h8001A5, 9'd0,   9'd0,     9'd0,     1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b0, 8'd0,          1'b0},
        '{ROW_REGS,  8'd0,   24'h0,      9'd3,   9'd49,    9'd20,    1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd20,         1'b0},
        '{ROW_REGS,  8'd0,   24'h0,      9'd3,   9'h1FF,   9'h100,   1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'hFF,         1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_REGS,  8'd0,   24'h0,      9'd0,   9'h1FF,   9'h100,   1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_REGS,  8'd0,   24'h0,      9'd511, 9'd0,     9'd255,   1'b0, 8'd0,          1'b0},
        '{ROW_WRITE, 8'd0,   24'h00FF00, 9'd0,   9'd0,     9'd0,     1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b0},
        '{ROW_REGS,  8'd0,   24'h0,      9'd1,   9'd0,     9'd255,   1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b0, 8'd0,          1'b0},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_SLOT,  8'd0,   24'h0,      9'd0,   9'd0,     9'd0,     1'b1, 8'd0,          1'b1},
        '{ROW_REGS,  8'd0,   24'h0,      9'd256, 9'd49,    9'd20,    1'b0, 8'd0,          1'b0},
        '{ROW_WRITE, 8'd255, 24'h5AC30F, 9'd0,   9'd0,     9'd0,     1'b0, 8'd0,          1'b0}
    };

    led_pwm_slot_encoder_unit #(
        .PIXEL_DEPTH(PIXEL_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Encode one item into the shadow store or into slot_duties
    function automatic bit encode_item(in_item_t it);
        logic [8:0]  eff_count;
        logic [23:0] send_bits;
        logic        gap;
        if (it.req_type == REQ_WRITE)
        begin
            shadow_pixels[it.pixel_index] = {it.red, it.green, it.blue};
            return 1'b0;
        end
        eff_count = (shadow_cfg.led_count > PIXEL_DEPTH) ? 9'(PIXEL_DEPTH)
                                                         : shadow_cfg.led_count;
        send_bits = '0;
        gap       = 1'b1;
        if (gap_owed)
        begin
            gap_owed = 1'b0;
        end
        else if (slot_pos >= eff_count)
        begin
            // frame done: first latch gap slot, restart at pixel 0
            gap_owed = 1'b1;
            slot_pos = '0;
        end
        else
        begin
            // blue, green, red, each MSB first
            send_bits = {shadow_pixels[slot_pos][7:0], shadow_pixels[slot_pos][15:8],
                         shadow_pixels[slot_pos][23:16]};
            gap       = 1'b0;
            slot_pos  = slot_pos + 9'd1;
        end
        for (int k = 0; k < BITS_PER_PIXEL; k++)
        begin
            slot_duties[k].duty_value   = gap ? 8'd0 :
                send_bits[BITS_PER_PIXEL-1-k] ? shadow_cfg.one_duty : shadow_cfg.zero_duty;
            slot_duties[k].is_gap       = gap;
            slot_duties[k].last_of_slot = (k == BITS_PER_PIXEL - 1);
        end
        return 1'b1;
    endfunction

    // Break the input stream into bursts with idle gaps between most of them
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Offer one item, hold it until taken, then queue its duty values
    task automatic offer_item(input in_item_t it, input bit typed, input logic [7:0] t_duty,
                              input logic t_gap);
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        if (encode_item(it))
        begin
            slots_sent++;
            for (int k = 0; k < BITS_PER_PIXEL; k++)
                pending_duties.push_back(typed ? out_item_t'{t_duty, t_gap,
                    k == BITS_PER_PIXEL - 1} : slot_duties[k]);
        end
    endtask

    // Drop valid and let the block drain completely
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [8:0] lc, input logic [8:0] one,
                                input logic [8:0] zero);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LED_COUNT;
        cfg_data  <= lc;
        @(posedge clk);
        cfg_index <= REG_ONE_DUTY;
        cfg_data  <= one;
        @(posedge clk);
        cfg_index <= REG_ZERO_DUTY;
        cfg_data  <= zero;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_cfg.led_count = lc;
        shadow_cfg.one_duty  = one[7:0];
        shadow_cfg.zero_duty = zero[7:0];
        settings_done++;
    endtask

    // Compare each accepted result with the oldest queued duty value
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_taken++;
            if (pending_duties.size() == 0)
            begin
                $error("unexpected result: duty_value %0d is_gap %0d last_of_slot %0d",
                       result.duty_value, result.is_gap, result.last_of_slot);
                errors++;
            end
            else
            begin
                if (result.duty_value !== pending_duties[0].duty_value)
                begin
                    $error("duty_value: expected %0d, got %0d",
                           pending_duties[0].duty_value, result.duty_value);
                    errors++;
                end
                if (result.is_gap !== pending_duties[0].is_gap)
                begin
                    $error("is_gap: expected %0d, got %0d",
                           pending_duties[0].is_gap, result.is_gap);
                    errors++;
                end
                if (result.last_of_slot !== pending_duties[0].last_of_slot)
                begin
                    $error("last_of_slot: expected %0d, got %0d",
                           pending_duties[0].last_of_slot, result.last_of_slot);
                    errors++;
                end
                void'(pending_duties.pop_front());
            end
        end
    end

    // Receiver: switch at random between stall patterns, with one long hold-off
    // placed in the middle of a random phase while items keep coming
    initial
    begin : receiver
        rx_mode_e rx_mode;
        int       mode_left;
        bit       held;
        rx_mode   = RX_STEADY;
        mode_left = 0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && items_sent >= HOLD_AFTER)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 80);
            end
            mode_left--;
            case (rx_mode)
                RX_STEADY: result_ready <= 1'b1;
                RX_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                default:   result_ready <= mode_left[2];
            endcase
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        in_item_t it;
        int       span;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        result_ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_LED_COUNT;
        cfg_data      = '0;
        errors        = 0;
        results_taken = 0;
        items_sent    = 0;
        slots_sent    = 0;
        settings_done = 0;
        burst_left    = 0;
        quiet_cycles  = 0;
        for (int i = 0; i < PIXEL_DEPTH; i++)
            shadow_pixels[i] = '0;
        shadow_cfg = '{LED_COUNT_RST, ONE_DUTY_RST, ZERO_DUTY_RST};
        slot_pos   = '0;
        gap_owed   = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (plan[r].kind == ROW_REGS)
            begin
                settle();
                program_regs(plan[r].lc, plan[r].one, plan[r].zero);
            end
            else
            begin
                it.req_type              = (plan[r].kind == ROW_WRITE) ? REQ_WRITE : REQ_SLOT;
                it.pixel_index           = plan[r].index;
                {it.red, it.green, it.blue} = plan[r].rgb;
                pace_sender();
                offer_item(it, plan[r].typed, plan[r].duty, plan[r].gap);
            end
        end

        // Random phases, each with a fresh register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case ($urandom_range(0, 7))
                0:       span = 0;
                1:       span = 1;
                2, 3, 4: span = $urandom_range(2, 6);
                5:       span = $urandom_range(7, 12);
                6:       span = 256;
                default: span = $urandom_range(257, 511);
            endcase
            program_regs(9'(span),
                         ($urandom_range(0, 3) == 0) ? 9'h0FF : 9'($urandom),
                         ($urandom_range(0, 3) == 0) ? 9'h000 : 9'($urandom));
            span = (span == 0) ? 7 : (span > PIXEL_DEPTH) ? PIXEL_DEPTH - 1 : span - 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                it.req_type = ($urandom_range(0, 99) < 35) ? REQ_WRITE : REQ_SLOT;
                it.red      = 8'($urandom);
                it.green    = 8'($urandom);
                it.blue     = 8'($urandom);
                // mostly pixels that this frame will send
                if (it.req_type == REQ_WRITE && $urandom_range(0, 4) != 0)
                    it.pixel_index = 8'($urandom_range(0, span));
                else
                    it.pixel_index = 8'($urandom);
                pace_sender();
                offer_item(it, 1'b0, 8'd0, 1'b0);
            end
        end

        settle();
        if (pending_duties.size() != 0)
        begin
            $error("%0d duty values never arrived", pending_duties.size());
            errors++;
        end
        $display("Sent %0d items (%0d slot items) over %0d register settings;",
                 items_sent, slots_sent, settings_done);
        $display("checked %0d duty values, %0d mismatches.", results_taken, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
